// File: rtl/msp_pkg.sv
// Package for the MSP request frame parser.
// Holds header byte codes, parser state and result kind enums, and the result struct.
// No dependencies; imported by every module in rtl.
package msp_pkg;

  localparam logic [7:0] HdrDollar      = 8'h24;
  localparam logic [7:0] HdrM           = 8'h4D;
  localparam logic [7:0] HdrArrow       = 8'h3C;
  localparam logic [7:0] MaxSizeReset   = 8'd128;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_DOLLAR = 3'd1,
    ST_M      = 3'd2,
    ST_ARROW  = 3'd3,
    ST_SIZE   = 3'd4,
    ST_CMD    = 3'd5
  } parse_state_e;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_BAD     = 2'd2
  } kind_e;

  typedef struct packed {
    logic       valid;
    kind_e      kind;
    logic [7:0] command_id;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic [7:0] frame_size;
  } result_t;

endpackage

// File: rtl/msp_parse.sv
// Frame recognizer state and per-byte result logic of the MSP parser.
// Consumes one registered byte per step and returns at most one result.
// Depends on msp_pkg.
module msp_parse (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       byte_i,
  input  logic [7:0]       max_size_i,
  output msp_pkg::result_t res_o
);
  import msp_pkg::*;

  parse_state_e state_q, state_d;
  logic [7:0]   size_q, size_d;
  logic [7:0]   cnt_q, cnt_d;
  logic [7:0]   xor_q, xor_d;
  logic [7:0]   cmd_q, cmd_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      size_q  <= 8'd0;
      cnt_q   <= 8'd0;
      xor_q   <= 8'd0;
      cmd_q   <= 8'd0;
    end else if (step_i) begin
      state_q <= state_d;
      size_q  <= size_d;
      cnt_q   <= cnt_d;
      xor_q   <= xor_d;
      cmd_q   <= cmd_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    size_d           = size_q;
    cnt_d            = cnt_q;
    xor_d            = xor_q;
    cmd_d            = cmd_q;
    res_o.valid      = 1'b0;
    res_o.kind       = KIND_PAYLOAD;
    res_o.command_id = cmd_q;
    res_o.data_byte  = byte_i;
    res_o.byte_index = 8'd0;
    res_o.frame_size = size_q;
    case (state_q)
      ST_DOLLAR: begin
        state_d = (byte_i == HdrM) ? ST_M : ST_IDLE;
      end
      ST_M: begin
        state_d = (byte_i == HdrArrow) ? ST_ARROW : ST_IDLE;
      end
      ST_ARROW: begin
        if (byte_i > max_size_i) begin
          state_d = ST_IDLE;
        end else begin
          size_d  = byte_i;
          cnt_d   = 8'd0;
          xor_d   = byte_i;
          state_d = ST_SIZE;
        end
      end
      ST_SIZE: begin
        cmd_d   = byte_i;
        xor_d   = xor_q ^ byte_i;
        state_d = ST_CMD;
      end
      ST_CMD: begin
        res_o.valid = 1'b1;
        if (cnt_q < size_q) begin
          xor_d            = xor_q ^ byte_i;
          cnt_d            = cnt_q + 8'd1;
          res_o.byte_index = cnt_q;
        end else begin
          res_o.kind = (xor_q == byte_i) ? KIND_GOOD : KIND_BAD;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = (byte_i == HdrDollar) ? ST_DOLLAR : ST_IDLE;
      end
    endcase
  end

  a_end_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.valid && res_o.kind != KIND_PAYLOAD |=> state_q == ST_IDLE)
    else $error("parser did not return to idle after checksum");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CMD |-> cnt_q <= size_q)
    else $error("payload count exceeds declared size");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.valid && res_o.kind == KIND_PAYLOAD |=> cnt_q == $past(cnt_q) + 8'd1)
    else $error("payload count did not advance");

  a_result_in_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> state_q == ST_CMD)
    else $error("result outside payload phase");

endmodule

// File: rtl/msp_out_reg.sv
// Result register of the MSP parser driving the master stream side.
// Holds one result until the downstream transfer completes.
// Depends on msp_pkg.
module msp_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  msp_pkg::result_t res_i,
  output logic             free_o,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [31:0]      m_axis_tdata,
  output logic [1:0]       m_axis_tuser
);
  import msp_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  assign free_o = !valid_q || m_axis_tready;

  always_comb begin
    valid_d = valid_q;
    if (free_o) begin
      valid_d = push_i && res_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && push_i && res_i.valid) begin
      res_q <= res_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {res_q.frame_size, res_q.byte_index, res_q.data_byte, res_q.command_id};
  assign m_axis_tuser  = res_q.kind;

endmodule

// File: rtl/msp_frame_parser.sv
// Top level of the MSP v1 request frame parser.
// Instantiates msp_parse and msp_out_reg; depends on msp_pkg.
//
// Usage: received bytes enter on the slave stream (tdata holds one byte).
// Each byte is captured in an input register and parsed once the output
// register is free; any result lands in the output register and is offered
// on the master stream from there. One byte per cycle is sustained while the
// receiver keeps up; the parse step and the XOR update form the only path
// between input and result registers.
// Master tdata holds command_id, data_byte, byte_index and frame_size from
// bit 0 up, one byte each; tuser holds the kind (payload, good, bad).
// A header byte that does not match, or a size above the size limit,
// returns the parser to idle without a result.
// Reset empties both registers, puts the parser in idle and sets the size
// limit to 128. When the receiver stalls, the held result waits and the input
// register fills, after which s_axis_tready drops until the result is taken.
// The user writes the size limit through cfg_we_i while idle; it is not enforced.
module msp_frame_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // command_id, data_byte, byte_index, frame_size
  output logic [1:0]  m_axis_tuser    // kind
);
  import msp_pkg::*;

  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic [7:0] max_size_q;
  logic       out_free;
  logic       step;
  result_t    res;

  assign step          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || step;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tready) begin
      in_valid_d = s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      max_size_q <= MaxSizeReset;
    end else begin
      in_valid_q <= in_valid_d;
      if (cfg_we_i) begin
        max_size_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  msp_parse u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .byte_i     (in_byte_q),
    .max_size_i (max_size_q),
    .res_o      (res)
  );

  msp_out_reg u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (step),
    .res_i         (res),
    .free_o        (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for msp_frame_parser, a byte-serial MSP v1 request parser.
// Drives framed and noisy byte streams under random flow control and checks each
// output transfer against an in-bench parser model; depends on rtl/msp_pkg.sv.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import msp_pkg::*;

  localparam int WatchdogLimit = 3000;
  localparam int DrainCycles   = 4;

  typedef struct {
    kind_e      kind;
    logic [7:0] cmd;
    logic [7:0] data;
    logic [7:0] idx;
    logic [7:0] size;
  } frame_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [7:0]  cfg_wdata_i = 8'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;   // rx_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;          // command_id, data_byte, byte_index, frame_size
  logic [1:0]  m_axis_tuser;          // kind

  msp_frame_parser dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #4 clk_i = ~clk_i;

  parse_state_e  parse_st = ST_IDLE;
  logic [7:0]    max_size = MaxSizeReset;
  logic [7:0]    frame_len = 8'd0;
  logic [7:0]    got_count = 8'd0;
  logic [7:0]    csum = 8'd0;
  logic [7:0]    cmd_code = 8'd0;
  frame_result_t pending_results[$];

  int mismatch_count = 0;
  int bytes_sent = 0;
  int burst_left = 0;
  int hold_request = 0;
  int hold_left = 0;
  int rx_mode = 0;
  int mode_left = 0;
  int idle_cycles = 0;
  int cycle_count = 0;

  function automatic void parse_rx_byte(input logic [7:0] b);
    frame_result_t r;
    case (parse_st)
      ST_DOLLAR: begin
        if (b == HdrM) parse_st = ST_M;
        else parse_st = ST_IDLE;
      end
      ST_M: begin
        if (b == HdrArrow) parse_st = ST_ARROW;
        else parse_st = ST_IDLE;
      end
      ST_ARROW: begin
        if (b > max_size) begin
          parse_st = ST_IDLE;
        end else begin
          frame_len = b;
          got_count = 8'd0;
          csum = b;
          parse_st = ST_SIZE;
        end
      end
      ST_SIZE: begin
        cmd_code = b;
        csum = csum ^ b;
        parse_st = ST_CMD;
      end
      ST_CMD: begin
        r.cmd = cmd_code;
        r.data = b;
        r.size = frame_len;
        if (got_count < frame_len) begin
          r.kind = KIND_PAYLOAD;
          r.idx = got_count;
          csum = csum ^ b;
          got_count = got_count + 8'd1;
        end else begin
          if (csum == b) r.kind = KIND_GOOD;
          else r.kind = KIND_BAD;
          r.idx = 8'd0;
          parse_st = ST_IDLE;
        end
        pending_results.push_back(r);
      end
      default: begin
        if (b == HdrDollar) parse_st = ST_DOLLAR;
        else parse_st = ST_IDLE;
      end
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 9) == 0) burst_left = $urandom_range(100, 200);
      else burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    parse_rx_byte(b);
    bytes_sent++;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_max_size(input logic [7:0] v);
    drain_results();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    max_size = v;
  endtask

  task automatic send_frame(input logic [7:0] len, input logic [7:0] cmd, input bit corrupt);
    logic [7:0] chk;
    logic [7:0] b;
    send_byte(HdrDollar);
    send_byte(HdrM);
    send_byte(HdrArrow);
    send_byte(len);
    send_byte(cmd);
    chk = len ^ cmd;
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom);
      chk = chk ^ b;
      send_byte(b);
    end
    if (corrupt) chk = chk ^ (8'h01 << $urandom_range(0, 7));
    send_byte(chk);
  endtask

  task automatic send_random_frame();
    logic [7:0] lim;
    logic [7:0] len;
    lim = (max_size < 8'd12) ? max_size : 8'd12;
    if ($urandom_range(0, 19) == 0) len = 8'($urandom_range(0, max_size));
    else len = 8'($urandom_range(0, lim));
    send_frame(len, 8'($urandom), $urandom_range(0, 6) == 0);
  endtask

  task automatic send_broken_header();
    logic [7:0] hdr[3];
    logic [7:0] b;
    int n;
    hdr[0] = HdrDollar;
    hdr[1] = HdrM;
    hdr[2] = HdrArrow;
    n = $urandom_range(0, 2);
    for (int i = 0; i < n; i++) send_byte(hdr[i]);
    b = 8'($urandom);
    if (b == hdr[n]) b = b ^ 8'h01;
    send_byte(b);
  endtask

  task automatic test_directed();
    send_frame(8'd0, 8'hFF, 1'b0);
    send_byte(HdrDollar);
    send_byte(HdrM);
    send_byte(HdrArrow);
    send_byte(8'd2);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hFC);
    send_byte(HdrDollar);
    send_byte(8'h58);
    send_byte(HdrDollar);
    send_byte(HdrM);
    send_byte(8'h58);
    send_byte(HdrDollar);
    send_byte(HdrDollar);
    send_byte(HdrM);
    send_byte(HdrDollar);
    send_byte(HdrM);
    send_byte(HdrArrow);
    send_byte(8'd129);
    drain_results();
  endtask

  task automatic test_size_limit();
    logic [7:0] limits[5];
    limits[0] = 8'd0;
    limits[1] = 8'd255;
    limits[2] = 8'd1;
    limits[3] = 8'($urandom_range(2, 40));
    limits[4] = MaxSizeReset;
    foreach (limits[i]) begin
      write_max_size(limits[i]);
      send_frame(limits[i], 8'($urandom), 1'b0);
      send_frame(8'd0, 8'($urandom), 1'b1);
      if (limits[i] != 8'd255) send_frame(limits[i] + 8'd1, 8'($urandom), 1'b0);
    end
    drain_results();
  endtask

  task automatic test_backpressure();
    drain_results();
    hold_request = 400;
    send_frame(8'd20, 8'($urandom), 1'b0);
    send_frame(8'd3, 8'($urandom), 1'b1);
    drain_results();
  endtask

  task automatic test_random_stream();
    logic [7:0] limits[4];
    int stop_at;
    int n;
    limits[0] = 8'($urandom_range(1, 254));
    limits[1] = 8'd255;
    limits[2] = 8'($urandom_range(0, 20));
    limits[3] = MaxSizeReset;
    foreach (limits[p]) begin
      write_max_size(limits[p]);
      stop_at = bytes_sent + 312;
      while (bytes_sent < stop_at) begin
        n = $urandom_range(0, 99);
        if (n < 70) begin
          send_random_frame();
        end else if (n < 80) begin
          repeat ($urandom_range(1, 5)) send_byte(8'($urandom));
        end else if (n < 90) begin
          send_broken_header();
        end else if (max_size != 8'd255) begin
          send_byte(HdrDollar);
          send_byte(HdrM);
          send_byte(HdrArrow);
          send_byte(8'($urandom_range(max_size + 1, 255)));
          repeat ($urandom_range(0, 3)) send_byte(8'($urandom));
        end else begin
          send_random_frame();
        end
      end
    end
    drain_results();
  endtask

  always @(posedge clk_i) begin
    frame_result_t e;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      cycle_count++;
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result kind=%0d tdata=%h", $time, m_axis_tuser,
                   m_axis_tdata);
        end else begin
          e = pending_results.pop_front();
          if (m_axis_tuser != e.kind || m_axis_tdata[7:0] != e.cmd ||
              m_axis_tdata[15:8] != e.data || m_axis_tdata[23:16] != e.idx ||
              m_axis_tdata[31:24] != e.size) begin
            mismatch_count++;
            $display("%0t: expected kind=%0d cmd=%h data=%h idx=%0d size=%0d", $time,
                     e.kind, e.cmd, e.data, e.idx, e.size);
            $display("%0t: actual   kind=%0d cmd=%h data=%h idx=%0d size=%0d", $time,
                     m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[15:8],
                     m_axis_tdata[23:16], m_axis_tdata[31:24]);
          end
        end
      end
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (rx_mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(0, 1));
          2: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= (cycle_count % 5 != 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WatchdogLimit) begin
          $display("tb_top: errors");
          $finish;
        end
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_size_limit();
    test_backpressure();
    test_random_stream();
    drain_results();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
